### src/plob_pkg.sv
// Package: shared types and constants for the price level order book.
package plob_pkg;
    localparam int NUM_INSTRUMENTS = 4;
    localparam int LEVELS_PER_SIDE = 32;
    localparam int MAX_DEPTH = 8;
    localparam int INST_W = 2;
    localparam int CNT_W = $clog2(LEVELS_PER_SIDE + 1);
    localparam int POS_W = (LEVELS_PER_SIDE > 1) ? $clog2(LEVELS_PER_SIDE) : 1;
    localparam int LANE_W = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;

    typedef enum logic [1:0] {
        KIND_BID = 2'd0,
        KIND_ASK = 2'd1,
        KIND_BBO = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_UPDATE,
        ST_CHECK,
        ST_PUB
    } t_state;

    // one cell operation broadcast to the row
    typedef struct packed {
        logic        en;
        logic        clear;
        logic        desc;
        logic [31:0] price;
        logic [31:0] qty;
    } t_cell_cmd;

    // per cell flags back to the controller
    typedef struct packed {
        logic valid;
        logic found;
        logic ahead;
    } t_cell_stat;
endpackage

### src/plob_cell.sv
// One level cell of a sorted side: holds price and quantity, shifts with neighbors.
module plob_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  plob_pkg::t_cell_cmd  i_cmd,
    input  logic                 i_lvalid,
    input  logic                 i_lbefore,
    input  logic                 i_lfound,
    input  logic [31:0]          i_lprice,
    input  logic [31:0]          i_lqty,
    input  logic                 i_rvalid,
    input  logic [31:0]          i_rprice,
    input  logic [31:0]          i_rqty,
    input  logic                 i_ins_ok,
    output plob_pkg::t_cell_stat o_stat,
    output logic [31:0]          o_price,
    output logic [31:0]          o_qty
);
    logic        r_valid;
    logic [31:0] r_price;
    logic [31:0] r_qty;
    logic        w_before;
    logic        w_found;
    logic        w_left_found;

    assign w_found  = r_valid && (r_price == i_cmd.price);
    assign w_before = r_valid && (i_cmd.desc ? (r_price > i_cmd.price)
                                             : (r_price < i_cmd.price));
    // a found cell to the left means this cell moves left on removal
    assign w_left_found = i_lfound;
    assign o_stat  = '{valid: r_valid, found: w_found, ahead: w_before};
    assign o_price = r_price;
    assign o_qty   = r_qty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.en) begin
            if (i_cmd.clear) begin
                r_valid <= 1'b0;
            end else if (i_cmd.qty == 32'd0) begin
                if (w_found || w_left_found) begin
                    r_valid <= i_rvalid;
                    r_price <= i_rprice;
                    r_qty   <= i_rqty;
                end
            end else if (w_found) begin
                r_qty <= i_cmd.qty;
            end else if (i_ins_ok && !w_before) begin
                // insert point is the first cell not ahead of the new price
                if (i_lbefore) begin
                    r_valid <= 1'b1;
                    r_price <= i_cmd.price;
                    r_qty   <= i_cmd.qty;
                end else begin
                    r_valid <= i_lvalid;
                    r_price <= i_lprice;
                    r_qty   <= i_lqty;
                end
            end
        end
    end
endmodule

### src/plob_side.sv
// A row of level cells for one side of one instrument.
module plob_side (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plob_pkg::t_cell_cmd i_cmd,
    input  logic [plob_pkg::POS_W-1:0] i_rd_idx,
    output logic [plob_pkg::CNT_W-1:0] o_count,
    output logic [31:0]         o_rd_price,
    output logic [31:0]         o_rd_qty,
    output logic [31:0]         o_top_price,
    output logic [31:0]         o_top_qty,
    output logic                o_ovf
);
    localparam int N = plob_pkg::LEVELS_PER_SIDE;
    plob_pkg::t_cell_stat w_stat [N];
    logic [31:0] w_price [N];
    logic [31:0] w_qty   [N];
    logic [N-1:0] w_valid;
    logic [N-1:0] w_found;
    logic [N-1:0] w_foundpre;
    logic        w_any_found;
    logic        w_full;
    logic [plob_pkg::CNT_W-1:0] r_count;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_valid[i] = w_stat[i].valid;
            w_found[i] = w_stat[i].found;
        end
        w_foundpre[0] = 1'b0;
        for (int i = 1; i < N; i++) w_foundpre[i] = w_foundpre[i-1] | w_found[i-1];
    end

    assign w_any_found = |w_found;
    assign w_full      = w_valid[N-1];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            if (g == 0) begin : g_first
                plob_cell u_cell (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd),
                    .i_lvalid(1'b0), .i_lbefore(1'b1), .i_lfound(1'b0),
                    .i_lprice(32'd0), .i_lqty(32'd0),
                    .i_rvalid((N > 1) ? w_valid[(g+1)%N] : 1'b0),
                    .i_rprice(w_price[(g+1)%N]), .i_rqty(w_qty[(g+1)%N]),
                    .i_ins_ok(!w_any_found && !w_full),
                    .o_stat(w_stat[g]), .o_price(w_price[g]), .o_qty(w_qty[g]));
            end else begin : g_rest
                plob_cell u_cell (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd),
                    .i_lvalid(w_valid[g-1]), .i_lbefore(w_stat[g-1].ahead),
                    .i_lfound(w_foundpre[g]),
                    .i_lprice(w_price[g-1]), .i_lqty(w_qty[g-1]),
                    .i_rvalid((g == N-1) ? 1'b0 : w_valid[(g+1)%N]),
                    .i_rprice(w_price[(g+1)%N]), .i_rqty(w_qty[(g+1)%N]),
                    .i_ins_ok(!w_any_found && !w_full),
                    .o_stat(w_stat[g]), .o_price(w_price[g]), .o_qty(w_qty[g]));
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.en) begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.qty == 32'd0) begin
                if (w_any_found) r_count <= r_count - 1'b1;
            end else if (!w_any_found && !w_full) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_ovf       = i_cmd.en && !i_cmd.clear && (i_cmd.qty != 32'd0)
                         && !w_any_found && w_full;
    assign o_count     = r_count;
    assign o_rd_price  = w_price[i_rd_idx];
    assign o_rd_qty    = w_qty[i_rd_idx];
    assign o_top_price = w_price[0];
    assign o_top_qty   = w_qty[0];
endmodule

### src/price_level_order_book.sv
// Price level order book top: per instrument cell rows, update and publish control.
// Steps per request: capture, snapshot clear, cell shift, check; a publication then loads
// one record per cycle while the output is not stalled, up to 17 records.
// A new request is accepted only in idle, after the previous one and its publication finish.
// Reset: synchronous active low; clears cell valid bits, counts, overflow flags; depth 5.
module price_level_order_book (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_instrument,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_quantity,
    input  logic        i_snapshot,
    input  logic        i_first_of_message,
    input  logic        i_last_of_message,
    input  logic [63:0] i_receive_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_instrument_out,
    output logic [63:0] o_time_out,
    output logic [1:0]  o_record_kind,
    output logic [2:0]  o_level_index,
    output logic [31:0] o_price_out,
    output logic [31:0] o_quantity_out,
    output logic [31:0] o_best_ask_price,
    output logic [31:0] o_best_ask_quantity,
    output logic        o_overflow,
    output logic        o_last
);
    localparam int NI = plob_pkg::NUM_INSTRUMENTS;
    localparam int CW = plob_pkg::CNT_W;
    localparam int PW = plob_pkg::POS_W;
    localparam int LANE_SEL = plob_pkg::LANE_W;

    plob_pkg::t_state r_state, n_state;
    plob_pkg::t_kind  r_kind;
    logic [3:0]  r_depth;
    logic [1:0]  r_inst;
    logic        r_side, r_clr, r_lastm;
    logic [31:0] r_price, r_qty;
    logic [63:0] r_time;
    logic [NI-1:0] r_ovf;
    logic [3:0]  r_nb, r_na, r_idx;

    plob_pkg::t_cell_cmd w_cmd [NI][2];
    logic [CW-1:0] w_cnt [NI][2];
    logic [31:0] w_rp [NI][2];
    logic [31:0] w_rq [NI][2];
    logic [31:0] w_tp [NI][2];
    logic [31:0] w_tq [NI][2];
    logic        w_ovf [NI][2];
    logic [PW-1:0] w_rd_idx;
    logic        w_inst_ok;
    logic [LANE_SEL-1:0] w_lane;
    logic [CW-1:0] w_bc, w_ac;
    logic [3:0]  w_dep;
    logic [3:0]  w_nb, w_na;
    logic        w_step;
    logic        w_rec_last;

    assign w_lane    = r_inst[LANE_SEL-1:0];
    assign w_inst_ok = 32'(r_inst) < NI;
    assign w_rd_idx  = PW'(r_idx);

    always_comb begin
        for (int i = 0; i < NI; i++) begin
            for (int s = 0; s < 2; s++) begin
                w_cmd[i][s].en    = w_inst_ok && (32'(r_inst) == i) &&
                                    ((r_state == plob_pkg::ST_CLEAR && r_clr) ||
                                     (r_state == plob_pkg::ST_UPDATE && r_side == s[0]));
                w_cmd[i][s].clear = (r_state == plob_pkg::ST_CLEAR);
                w_cmd[i][s].desc  = (s == 0);
                w_cmd[i][s].price = r_price;
                w_cmd[i][s].qty   = r_qty;
            end
        end
    end

    genvar gi, gs;
    generate
        for (gi = 0; gi < NI; gi++) begin : g_inst
            for (gs = 0; gs < 2; gs++) begin : g_side
                plob_side u_side (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd[gi][gs]),
                    .i_rd_idx(w_rd_idx), .o_count(w_cnt[gi][gs]),
                    .o_rd_price(w_rp[gi][gs]), .o_rd_qty(w_rq[gi][gs]),
                    .o_top_price(w_tp[gi][gs]), .o_top_qty(w_tq[gi][gs]),
                    .o_ovf(w_ovf[gi][gs]));
            end
        end
    endgenerate

    assign w_bc  = w_cnt[w_lane][0];
    assign w_ac  = w_cnt[w_lane][1];
    assign w_dep = (r_depth == 4'd0) ? 4'd1 :
                   (32'(r_depth) > plob_pkg::MAX_DEPTH) ? 4'(plob_pkg::MAX_DEPTH) : r_depth;
    assign w_nb  = (32'(w_bc) < 32'(w_dep)) ? 4'(w_bc) : w_dep;
    assign w_na  = (32'(w_ac) < 32'(w_dep)) ? 4'(w_ac) : w_dep;
    assign w_step = !o_valid || i_ready;
    assign w_rec_last = (r_kind == plob_pkg::KIND_BBO);

    assign o_ready     = (r_state == plob_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plob_pkg::ST_IDLE:   if (i_valid) n_state = plob_pkg::ST_CLEAR;
            plob_pkg::ST_CLEAR:  n_state = plob_pkg::ST_UPDATE;
            plob_pkg::ST_UPDATE: n_state = plob_pkg::ST_CHECK;
            plob_pkg::ST_CHECK: begin
                if (w_inst_ok && r_lastm && w_bc != '0 && w_ac != '0)
                    n_state = plob_pkg::ST_PUB;
                else
                    n_state = plob_pkg::ST_IDLE;
            end
            plob_pkg::ST_PUB:
                if (w_step && w_rec_last) n_state = plob_pkg::ST_IDLE;
            default: n_state = plob_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plob_pkg::ST_IDLE;
            r_depth <= 4'd5;
            r_ovf   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_depth <= i_cfg_data;
            if (r_state == plob_pkg::ST_PUB && w_step) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            if (r_state == plob_pkg::ST_CLEAR && r_clr && w_inst_ok) begin
                r_ovf[w_lane] <= 1'b0;
            end else if (r_state == plob_pkg::ST_UPDATE && w_inst_ok &&
                         (w_ovf[w_lane][0] || w_ovf[w_lane][1])) begin
                r_ovf[w_lane] <= 1'b1;
            end else if (r_state == plob_pkg::ST_PUB && w_step && w_rec_last) begin
                r_ovf[w_lane] <= 1'b0;
            end
        end
    end

    // request capture, record output register and walk pointer
    always_ff @(posedge i_clk) begin
        if (r_state == plob_pkg::ST_IDLE && i_valid) begin
            r_inst  <= i_instrument;
            r_side  <= i_side;
            r_price <= i_price;
            r_qty   <= i_quantity;
            r_clr   <= i_snapshot && i_first_of_message;
            r_lastm <= i_last_of_message;
            r_time  <= i_receive_time;
        end
        if (r_state == plob_pkg::ST_CHECK) begin
            r_nb   <= w_nb;
            r_na   <= w_na;
            r_idx  <= 4'd0;
            r_kind <= plob_pkg::KIND_BID;
        end
        if (r_state == plob_pkg::ST_PUB && w_step) begin
            o_instrument_out <= r_inst;
            o_time_out       <= r_time;
            o_record_kind    <= r_kind;
            o_overflow       <= r_ovf[w_lane];
            o_last           <= w_rec_last;
            o_level_index    <= w_rec_last ? 3'd0 : r_idx[2:0];
            o_best_ask_price    <= w_rec_last ? w_tp[w_lane][1] : 32'd0;
            o_best_ask_quantity <= w_rec_last ? w_tq[w_lane][1] : 32'd0;
            unique case (r_kind)
                plob_pkg::KIND_BID: begin
                    o_price_out    <= w_rp[w_lane][0];
                    o_quantity_out <= w_rq[w_lane][0];
                    if (r_idx + 4'd1 >= r_nb) begin
                        r_idx  <= 4'd0;
                        r_kind <= plob_pkg::KIND_ASK;
                    end else r_idx <= r_idx + 4'd1;
                end
                plob_pkg::KIND_ASK: begin
                    o_price_out    <= w_rp[w_lane][1];
                    o_quantity_out <= w_rq[w_lane][1];
                    if (r_idx + 4'd1 >= r_na) begin
                        r_idx  <= 4'd0;
                        r_kind <= plob_pkg::KIND_BBO;
                    end else r_idx <= r_idx + 4'd1;
                end
                default: begin
                    o_price_out    <= w_tp[w_lane][0];
                    o_quantity_out <= w_tq[w_lane][0];
                end
            endcase
        end
    end
endmodule

### sim/plob_checker.sv
`timescale 1ns / 100ps
// Checker: watches the request, record and depth channels, predicts the book and compares records.
module plob_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [1:0]  i_instrument,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_quantity,
    input  logic        i_snapshot,
    input  logic        i_first_of_message,
    input  logic        i_last_of_message,
    input  logic [63:0] i_receive_time,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_instrument_out,
    input  logic [63:0] i_time_out,
    input  logic [1:0]  i_record_kind,
    input  logic [2:0]  i_level_index,
    input  logic [31:0] i_price_out,
    input  logic [31:0] i_quantity_out,
    input  logic [31:0] i_best_ask_price,
    input  logic [31:0] i_best_ask_quantity,
    input  logic        i_overflow,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct {
        logic [1:0]      inst;
        logic [63:0]     stamp;
        plob_pkg::t_kind kind;
        logic [2:0]      rank;
        logic [31:0]     px;
        logic [31:0]     qty;
        logic [31:0]     ask_px;
        logic [31:0]     ask_qty;
        logic            ovf;
        logic            fin;
    } t_record;

    logic [31:0] bid_px  [plob_pkg::NUM_INSTRUMENTS][plob_pkg::LEVELS_PER_SIDE];
    logic [31:0] bid_qty [plob_pkg::NUM_INSTRUMENTS][plob_pkg::LEVELS_PER_SIDE];
    logic [31:0] ask_px  [plob_pkg::NUM_INSTRUMENTS][plob_pkg::LEVELS_PER_SIDE];
    logic [31:0] ask_qty [plob_pkg::NUM_INSTRUMENTS][plob_pkg::LEVELS_PER_SIDE];
    int          bid_cnt [plob_pkg::NUM_INSTRUMENTS];
    int          ask_cnt [plob_pkg::NUM_INSTRUMENTS];
    logic        ovf_seen[plob_pkg::NUM_INSTRUMENTS];
    logic [3:0]  depth_reg;
    t_record     expected_records[$];

    task automatic book_side_update(input int inst, input logic is_ask,
                                    input logic [31:0] p, input logic [31:0] q);
        int n;
        int pos;
        logic hit;
        n = is_ask ? ask_cnt[inst] : bid_cnt[inst];
        pos = 0;
        while (pos < n && (is_ask ? ask_px[inst][pos] < p : bid_px[inst][pos] > p))
            pos++;
        hit = (pos < n) && ((is_ask ? ask_px[inst][pos] : bid_px[inst][pos]) == p);
        if (q == 0) begin
            if (hit) begin
                for (int j = pos; j < n - 1; j++) begin
                    if (is_ask) begin
                        ask_px[inst][j] = ask_px[inst][j+1];
                        ask_qty[inst][j] = ask_qty[inst][j+1];
                    end else begin
                        bid_px[inst][j] = bid_px[inst][j+1];
                        bid_qty[inst][j] = bid_qty[inst][j+1];
                    end
                end
                if (is_ask) ask_cnt[inst]--; else bid_cnt[inst]--;
            end
        end else if (hit) begin
            if (is_ask) ask_qty[inst][pos] = q; else bid_qty[inst][pos] = q;
        end else if (n >= plob_pkg::LEVELS_PER_SIDE) begin
            ovf_seen[inst] = 1'b1;
        end else begin
            for (int j = n; j > pos; j--) begin
                if (is_ask) begin
                    ask_px[inst][j] = ask_px[inst][j-1];
                    ask_qty[inst][j] = ask_qty[inst][j-1];
                end else begin
                    bid_px[inst][j] = bid_px[inst][j-1];
                    bid_qty[inst][j] = bid_qty[inst][j-1];
                end
            end
            if (is_ask) begin
                ask_px[inst][pos] = p; ask_qty[inst][pos] = q; ask_cnt[inst]++;
            end else begin
                bid_px[inst][pos] = p; bid_qty[inst][pos] = q; bid_cnt[inst]++;
            end
        end
    endtask

    task automatic predict_book_update();
        int inst;
        int d;
        t_record r;
        inst = int'(i_instrument);
        if (inst >= plob_pkg::NUM_INSTRUMENTS) return;
        if (i_snapshot && i_first_of_message) begin
            bid_cnt[inst] = 0; ask_cnt[inst] = 0; ovf_seen[inst] = 1'b0;
        end
        book_side_update(inst, i_side, i_price, i_quantity);
        if (!i_last_of_message || bid_cnt[inst] == 0 || ask_cnt[inst] == 0) return;
        d = (depth_reg == 4'd0) ? 1 :
            ((int'(depth_reg) > plob_pkg::MAX_DEPTH) ? plob_pkg::MAX_DEPTH : int'(depth_reg));
        r.inst = 2'(inst); r.stamp = i_receive_time; r.ovf = ovf_seen[inst]; r.fin = 1'b0;
        r.ask_px = '0; r.ask_qty = '0;
        r.kind = plob_pkg::KIND_BID;
        for (int j = 0; j < d && j < bid_cnt[inst]; j++) begin
            r.rank = 3'(j); r.px = bid_px[inst][j]; r.qty = bid_qty[inst][j];
            expected_records.push_back(r);
        end
        r.kind = plob_pkg::KIND_ASK;
        for (int j = 0; j < d && j < ask_cnt[inst]; j++) begin
            r.rank = 3'(j); r.px = ask_px[inst][j]; r.qty = ask_qty[inst][j];
            expected_records.push_back(r);
        end
        r.kind = plob_pkg::KIND_BBO; r.rank = 3'd0; r.fin = 1'b1;
        r.px = bid_px[inst][0]; r.qty = bid_qty[inst][0];
        r.ask_px = ask_px[inst][0]; r.ask_qty = ask_qty[inst][0];
        expected_records.push_back(r);
        ovf_seen[inst] = 1'b0;
    endtask

    task automatic compare_record();
        t_record e;
        if (expected_records.size() == 0) begin
            $error("unexpected record: kind %0d price %0d", i_record_kind, i_price_out);
            o_fail_count++;
            return;
        end
        e = expected_records.pop_front();
        if (i_instrument_out !== e.inst) begin
            $error("instrument_out exp %0d got %0d", e.inst, i_instrument_out); o_fail_count++;
        end
        if (i_time_out !== e.stamp) begin
            $error("time_out exp %0d got %0d", e.stamp, i_time_out); o_fail_count++;
        end
        if (i_record_kind !== e.kind) begin
            $error("record_kind exp %0d got %0d", e.kind, i_record_kind); o_fail_count++;
        end
        if (i_level_index !== e.rank) begin
            $error("level_index exp %0d got %0d", e.rank, i_level_index); o_fail_count++;
        end
        if (i_price_out !== e.px) begin
            $error("price_out exp %0d got %0d", e.px, i_price_out); o_fail_count++;
        end
        if (i_quantity_out !== e.qty) begin
            $error("quantity_out exp %0d got %0d", e.qty, i_quantity_out); o_fail_count++;
        end
        if (i_best_ask_price !== e.ask_px) begin
            $error("best_ask_price exp %0d got %0d", e.ask_px, i_best_ask_price);
            o_fail_count++;
        end
        if (i_best_ask_quantity !== e.ask_qty) begin
            $error("best_ask_quantity exp %0d got %0d", e.ask_qty, i_best_ask_quantity);
            o_fail_count++;
        end
        if (i_overflow !== e.ovf) begin
            $error("overflow exp %0d got %0d", e.ovf, i_overflow); o_fail_count++;
        end
        if (i_last !== e.fin) begin
            $error("last exp %0d got %0d", e.fin, i_last); o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < plob_pkg::NUM_INSTRUMENTS; k++) begin
                bid_cnt[k] = 0; ask_cnt[k] = 0; ovf_seen[k] = 1'b0;
            end
            depth_reg = 4'd5;
            expected_records.delete();
        end else begin
            if (i_out_valid && i_out_ready) compare_record();
            if (i_cfg_valid && i_cfg_ready) depth_reg = i_cfg_data;
            if (i_valid && i_ready_in) predict_book_update();
        end
        o_pending = expected_records.size();
    end
endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: drives level update requests and depth writes, gives the verdict.
module tb_top;
    localparam int LIMIT_CYCLES = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  instrument;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic        snapshot;
    logic        first_of_msg;
    logic        last_of_msg;
    logic [63:0] receive_time;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  instrument_out;
    logic [63:0] time_out;
    logic [1:0]  record_kind;
    logic [2:0]  level_index;
    logic [31:0] price_out;
    logic [31:0] quantity_out;
    logic [31:0] best_ask_price;
    logic [31:0] best_ask_quantity;
    logic        overflow;
    logic        last_rec;
    int          fail_count;
    int          pending;
    int          cycle_count;
    logic        calm_phase;

    price_level_order_book u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_instrument(instrument), .i_side(side), .i_price(price), .i_quantity(quantity),
        .i_snapshot(snapshot), .i_first_of_message(first_of_msg),
        .i_last_of_message(last_of_msg), .i_receive_time(receive_time),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_instrument_out(instrument_out), .o_time_out(time_out),
        .o_record_kind(record_kind), .o_level_index(level_index),
        .o_price_out(price_out), .o_quantity_out(quantity_out),
        .o_best_ask_price(best_ask_price), .o_best_ask_quantity(best_ask_quantity),
        .o_overflow(overflow), .o_last(last_rec)
    );

    plob_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_ready_in(in_ready),
        .i_instrument(instrument), .i_side(side), .i_price(price), .i_quantity(quantity),
        .i_snapshot(snapshot), .i_first_of_message(first_of_msg),
        .i_last_of_message(last_of_msg), .i_receive_time(receive_time),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_instrument_out(instrument_out), .i_time_out(time_out),
        .i_record_kind(record_kind), .i_level_index(level_index),
        .i_price_out(price_out), .i_quantity_out(quantity_out),
        .i_best_ask_price(best_ask_price), .i_best_ask_quantity(best_ask_quantity),
        .i_overflow(overflow), .i_last(last_rec),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // record sink stalls in short bursts
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!calm_phase && rst_n && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // valid stays up after acceptance until the next request or an explicit drop
    task automatic send_level(input logic [1:0] inst, input logic sd, input logic [31:0] p,
                              input logic [31:0] q, input logic snap, input logic fst,
                              input logic lst);
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        instrument <= inst; side <= sd; price <= p; quantity <= q;
        snapshot <= snap; first_of_msg <= fst; last_of_msg <= lst;
        receive_time <= {$urandom, $urandom};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_depth(input logic [3:0] d);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one message: optional snapshot, random levels near a base, random side per level
    task automatic send_message(input int n_levels, input logic snap);
        logic [1:0]  inst;
        logic [31:0] base;
        inst = 2'($urandom_range(0, 3));
        base = ($urandom_range(0, 9) == 0) ? $urandom : 32'd1000;
        for (int k = 0; k < n_levels; k++)
            send_level(inst, 1'($urandom_range(0, 1)), base + 32'($urandom_range(0, 40)),
                       ($urandom_range(0, 4) == 0) ? 32'd0 :
                       (($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(1, 500))),
                       snap, k == 0, k == n_levels - 1);
    endtask

    initial begin
        int sent;
        logic depth_a_done;
        logic depth_b_done;
        rst_n = 1'b0; calm_phase = 1'b0;
        depth_a_done = 1'b0; depth_b_done = 1'b0;
        cfg_valid = 1'b0; cfg_data = '0;
        in_valid = 1'b0; instrument = '0; side = 1'b0; price = '0; quantity = '0;
        snapshot = 1'b0; first_of_msg = 1'b0; last_of_msg = 1'b0; receive_time = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, removal, absent removal, late snapshot, empty side
        send_level(2'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        send_level(2'd0, 1'b1, 32'd0, 32'd1, 1'b0, 1'b1, 1'b1);
        send_level(2'd0, 1'b1, 32'hFFFF_FFFE, 32'd7, 1'b0, 1'b1, 1'b1);
        send_level(2'd0, 1'b0, 32'd5, 32'd9, 1'b1, 1'b0, 1'b1);
        send_level(2'd0, 1'b0, 32'd77, 32'd0, 1'b0, 1'b1, 1'b1);
        send_level(2'd0, 1'b1, 32'd0, 32'd0, 1'b0, 1'b1, 1'b1);
        send_level(2'd3, 1'b1, 32'd10, 32'd3, 1'b1, 1'b1, 1'b1);
        send_level(2'd3, 1'b0, 32'd9, 32'd4, 1'b0, 1'b1, 1'b1);
        // fill one side to overflow
        for (int k = 0; k < 34; k++)
            send_level(2'd2, 1'b0, 32'd100 + 32'(k), 32'd1 + 32'(k), k == 0, k == 0, 1'b0);
        send_level(2'd2, 1'b1, 32'd500, 32'd2, 1'b0, 1'b0, 1'b1);
        send_level(2'd2, 1'b1, 32'd501, 32'd2, 1'b0, 1'b1, 1'b1);

        write_depth(4'd0);
        send_message(4, 1'b0);
        write_depth(4'd15);
        send_message(6, 1'b0);
        write_depth(4'd8);
        send_message(5, 1'b0);
        write_depth(4'd1);
        sent = 0;
        while (sent < 350) begin
            int n;
            if (!depth_a_done && sent >= 120) begin
                depth_a_done = 1'b1;
                write_depth(4'($urandom_range(2, 7)));
            end
            if (!depth_b_done && sent >= 240) begin
                depth_b_done = 1'b1;
                write_depth(4'd9);
            end
            if (sent >= 290) calm_phase = 1'b1;
            n = $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0) begin
                n = 1;
                send_level(2'($urandom), 1'($urandom), $urandom, $urandom, 1'($urandom),
                           1'($urandom), 1'($urandom));
            end else begin
                send_message(n, $urandom_range(0, 3) == 0);
            end
            sent += n;
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

### price_level_order_book.f
src/plob_pkg.sv
src/plob_cell.sv
src/plob_side.sv
src/price_level_order_book.sv
sim/plob_checker.sv
sim/tb_top.sv
